// ===== rtl/tes_pkg.sv =====
package tes_pkg;

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_UNSET = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam int          LIMIT_W   = 13;
  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0]        event_id;
    logic [LIMIT_W-1:0] limit;
    logic [15:0]        ticks;
  } slot_entry_t;

  typedef struct packed {
    logic        en;
    slot_entry_t data;
  } slot_wr_t;

endpackage

// ===== rtl/timed_event_slot_table.sv =====
// Set: accepted, then walks the slots in order up to the first free one (at most SLOT_COUNT slots).
// Unset and tick: accepted, then each occupied slot takes a memory read, then an evaluate step
// (tick also writes back), and each free slot a read step only, ending with the done or not-found
// item; an unset that matches ends at its slot instead. One request at a time.
// Results wait in an output register; a stalled result delays the walk.
// Reset (rst, synchronous) clears all occupied flags and the handshake state.
module timed_event_slot_table
  import tes_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  command,
  input  logic [15:0] event_id,
  input  logic [15:0] period_ms,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  kind,
  output logic [15:0] fired_id,
  output logic [1:0]  status,
  output logic        last
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EVAL,
    S_DONE
  } state_t;

  state_t                 state;
  logic [IDX_W-1:0]       idx;
  logic [SLOT_COUNT-1:0]  used;
  logic [1:0]             cmd;
  logic [15:0]            req_id;
  logic [LIMIT_W-1:0]     req_limit;
  logic [LIMIT_W-1:0]     limit_calc;

  slot_wr_t    wr;
  logic        rd_en;
  slot_entry_t rd_data;

  logic        accept;
  logic        out_free;
  logic        fire;
  logic        match;
  logic        res_load;
  logic [15:0] ticks_inc;

  tes_limit_calc u_limit (
    .period_ms (period_ms),
    .limit     (limit_calc)
  );

  tes_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (idx),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;
  assign fire      = ({3'b0, rd_data.limit} <= rd_data.ticks);
  assign match     = (rd_data.event_id == req_id);
  assign ticks_inc = fire ? 16'd1 :
                     (rd_data.ticks == TICKS_MAX) ? TICKS_MAX : rd_data.ticks + 16'd1;
  assign rd_en     = (state == S_READ) && used[idx];
  assign res_load  = out_free && (
                       ((state == S_SCAN) && (!used[idx] || idx == LastIdx)) ||
                       ((state == S_EVAL) && (((cmd == CMD_UNSET) && match) ||
                                              ((cmd == CMD_TICK) && fire))) ||
                       (state == S_DONE));

  always_comb begin
    wr.en   = 1'b0;
    wr.data = rd_data;
    unique case (state)
      S_SCAN: begin
        wr.data.event_id = req_id;
        wr.data.limit    = req_limit;
        wr.data.ticks    = 16'd0;
        wr.en            = !used[idx] && out_free;
      end
      S_EVAL: begin
        wr.data.ticks = ticks_inc;
        wr.en         = (cmd == CMD_TICK) && (!fire || out_free);
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      used      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd       <= command;
            req_id    <= event_id;
            req_limit <= limit_calc;
            idx       <= '0;
            if (command == CMD_SET) begin
              state <= S_SCAN;
            end else if (command == CMD_UNSET || command == CMD_TICK) begin
              state <= S_READ;
            end
          end
        end
        S_SCAN: begin
          if (!used[idx] || idx == LastIdx) begin
            if (out_free) begin
              kind      <= KIND_STATUS;
              fired_id  <= '0;
              status    <= used[idx] ? ST_FULL : ST_OK;
              last      <= 1'b1;
              if (!used[idx]) begin
                used[idx] <= 1'b1;
              end
              state <= S_IDLE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_READ: begin
          if (used[idx]) begin
            state <= S_EVAL;
          end else if (idx == LastIdx) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EVAL: begin
          if (cmd == CMD_UNSET && match) begin
            if (out_free) begin
              used[idx] <= 1'b0;
              kind      <= KIND_STATUS;
              fired_id  <= '0;
              status    <= ST_OK;
              last      <= 1'b1;
              state     <= S_IDLE;
            end
          end else if (cmd == CMD_TICK && fire && !out_free) begin
            state <= S_EVAL;
          end else begin
            if (cmd == CMD_TICK && fire) begin
              kind      <= KIND_FIRED;
              fired_id  <= rd_data.event_id;
              status    <= ST_OK;
              last      <= 1'b0;
            end
            if (idx == LastIdx) begin
              state <= S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            fired_id  <= '0;
            last      <= 1'b1;
            if (cmd == CMD_TICK) begin
              kind   <= KIND_DONE;
              status <= ST_OK;
            end else begin
              kind   <= KIND_STATUS;
              status <= ST_NOT_FOUND;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !wr.en)
    else $error("slot memory written while idle");

  a_set_free_slot: assert property (@(posedge clk) disable iff (rst)
    wr.en && state == S_SCAN |-> !used[idx])
    else $error("set overwrote an occupied slot");

  a_tick_walk: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_TICK |=> state == S_READ && idx == '0)
    else $error("tick did not start the walk at slot zero");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_DONE || kind == KIND_STATUS) |-> last)
    else $error("final result without last");
`endif

endmodule

// ===== rtl/tes_limit_calc.sv =====
module tes_limit_calc
  import tes_pkg::*;
(
  input  logic [15:0]        period_ms,
  output logic [LIMIT_W-1:0] limit
);

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [32:0] Recip = 33'd52429;

  logic [32:0] prod;

  assign prod  = 33'(period_ms) * Recip;
  assign limit = prod[19 +: LIMIT_W];

endmodule

// ===== rtl/tes_slot_mem.sv =====
module tes_slot_mem
  import tes_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic             clk,
  input  slot_wr_t         wr,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_entry_t      rd_data
);

  slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
